/* rtl/core/priority_topological_order_macros.svh */
// assertion macros shared by the priority ordering block
// no dependencies; included by the top level only
`ifndef PRIORITY_TOPOLOGICAL_ORDER_MACROS_SVH
`define PRIORITY_TOPOLOGICAL_ORDER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define POT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pot assertion failed");
// next-cycle implication
`define POT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pot assertion failed");
`else
`define POT_ASSERT_NOW(label, clk, rst, ante, cons)
`define POT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/pot_pkg.sv */
// shared constants and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pot_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = 4;
  localparam int MASK_W    = 16;
  localparam int POS_W     = $clog2(MAX_TASKS);
  localparam int LEN_W     = $clog2(MAX_TASKS + 1);
  localparam int ENTRY_W   = TASK_W + MASK_W;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // store the accepted word
    logic scan_init;   // start ordering on the stored list
    logic scan_run;    // keep scanning the list memory
    logic emit_found;  // capture the qualifying entry as result
    logic emit_stuck;  // capture a stuck result
    logic rescan;      // restart the scan from position zero
    logic list_clear;  // ordering finished, empty the list
  } pot_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic found;      // entry in check stage qualifies
    logic exhausted;  // whole list scanned with no qualifying entry
    logic final_out;  // held result is the last of the list
  } pot_status_t;

endpackage

`default_nettype wire

/* rtl/core/priority_topological_order.sv */
// Priority-list topological ordering. Input words load the priority list one entry per
// cycle (task number plus predecessor mask); the entry flagged last_item starts ordering,
// and no input is taken until the whole order has been delivered. Entries beyond
// MAX_TASKS are dropped. For each emitted task the list memory is scanned from position
// zero through its single read port, one entry per cycle, until the earliest untaken
// entry with all predecessors done is found; if no entry qualifies, a stuck result
// ends the list. Results are held until taken; after the last one the block returns
// to loading.
// depends on pot_pkg, pot_ctrl, pot_datapath and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "priority_topological_order_macros.svh"

module priority_topological_order
  import pot_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [TASK_W-1:0] task_id,
  input  wire logic [MASK_W-1:0] pred_mask,
  input  wire logic              last_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [TASK_W-1:0] task_id_res,
  output logic                   last_result,
  output logic                   stuck
);

  pot_cmd_t    cmd;
  pot_status_t status;

  pot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_item(last_item),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pot_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .task_id    (task_id),
    .pred_mask  (pred_mask),
    .task_id_res(task_id_res),
    .last_result(last_result),
    .stuck      (stuck)
  );

  // checks
  `POT_ASSERT_NOW(a_stuck_is_last, clk, rst, out_valid && stuck, last_result)
  `POT_ASSERT_NOW(a_stuck_task_zero, clk, rst, out_valid && stuck, task_id_res == '0)
  `POT_ASSERT_NOW(a_no_load_while_emit, clk, rst, in_valid && !in_stall, !out_valid)
  `POT_ASSERT_NEXT(a_ready_after_final, clk, rst, out_valid && !out_stall && last_result, !in_stall)

endmodule

`default_nettype wire

/* rtl/core/pot_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/pot_ctrl.sv */
// controller state machine: load, scan, emit sequencing
// depends on pot_pkg
`timescale 1ns / 1ps
`default_nettype none

module pot_ctrl
  import pot_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        last_item,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire pot_status_t status,
  output pot_cmd_t         cmd
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_take;

  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_EMIT);
  assign in_take   = in_valid && (state == S_LOAD);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (in_take) begin
          cmd.load = 1'b1;
          if (last_item) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.found) begin
          cmd.emit_found = 1'b1;
          state_next     = S_EMIT;
        end else if (status.exhausted) begin
          cmd.emit_stuck = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (status.final_out) begin
            cmd.list_clear = 1'b1;
            state_next     = S_LOAD;
          end else begin
            cmd.rescan = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pot_datapath.sv */
// datapath: list memory, scan pipeline, done/taken tracking, result register
// depends on pot_pkg and pot_ram
`timescale 1ns / 1ps
`default_nettype none

module pot_datapath
  import pot_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pot_cmd_t          cmd,
  output pot_status_t            status,
  input  wire logic [TASK_W-1:0] task_id,
  input  wire logic [MASK_W-1:0] pred_mask,
  output logic      [TASK_W-1:0] task_id_res,
  output logic                   last_result,
  output logic                   stuck
);

  logic [LEN_W-1:0]     list_length;
  logic [LEN_W-1:0]     scan_addr;
  logic [LEN_W-1:0]     remaining;
  logic                 chk_valid;
  logic [POS_W-1:0]     chk_pos;
  logic [MAX_TASKS-1:0] taken;
  logic [MASK_W-1:0]    done_mask;

  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [TASK_W-1:0]    rd_task;
  logic [MASK_W-1:0]    rd_pred;
  logic                 list_full;
  logic                 qual;
  logic                 issue;
  logic [LEN_W-1:0]     new_length;

  assign list_full  = (list_length == LEN_W'(MAX_TASKS));
  assign ram_we     = cmd.load && !list_full;
  assign new_length = list_full ? list_length : list_length + LEN_W'(1);

  pot_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_TASKS)
  ) u_list_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(list_length[POS_W-1:0]),
    .wdata({pred_mask, task_id}),
    .raddr(scan_addr[POS_W-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_task = ram_rdata[TASK_W-1:0];
  assign rd_pred = ram_rdata[ENTRY_W-1:TASK_W];

  // entry in check stage is untaken with all predecessors done
  assign qual  = chk_valid && !taken[chk_pos] && ((rd_pred & ~done_mask) == '0);
  assign issue = cmd.scan_run && !qual && (scan_addr < list_length);

  assign status.found     = qual;
  assign status.exhausted = !chk_valid && (scan_addr >= list_length);
  assign status.final_out = last_result;

  // list length
  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= '0;
    end else if (cmd.list_clear) begin
      list_length <= '0;
    end else if (ram_we) begin
      list_length <= list_length + LEN_W'(1);
    end
  end

  // scan address and check stage
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init || cmd.rescan) begin
      scan_addr <= '0;
    end else if (issue) begin
      scan_addr <= scan_addr + LEN_W'(1);
    end
    if (issue) begin
      chk_pos <= scan_addr[POS_W-1:0];
    end
  end

  // taken bits and done mask
  always_ff @(posedge clk) begin
    if (rst) begin
      taken     <= '0;
      done_mask <= '0;
    end else if (cmd.scan_init || cmd.list_clear) begin
      taken     <= '0;
      done_mask <= '0;
    end else if (cmd.emit_found) begin
      taken[chk_pos] <= 1'b1;
      done_mask      <= done_mask | (MASK_W'(1) << rd_task);
    end
  end

  // remaining count and result word
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      remaining <= new_length;
    end else if (cmd.emit_found) begin
      remaining <= remaining - LEN_W'(1);
    end
    if (cmd.emit_found) begin
      task_id_res <= rd_task;
      last_result <= (remaining == LEN_W'(1));
      stuck       <= 1'b0;
    end else if (cmd.emit_stuck) begin
      task_id_res <= '0;
      last_result <= 1'b1;
      stuck       <= 1'b1;
    end
  end

endmodule

`default_nettype wire
